### hdl/ladf_pkg.sv
package ladf_pkg;

  localparam int unsigned LOG_W        = 14;
  localparam int unsigned LOG_OFFSET   = 2000;
  localparam real         LOG_SCALE    = 1000.0;

  localparam int unsigned THR_W        = 10;
  localparam logic [THR_W-1:0] THR_RESET = 10'd50;

  localparam logic [7:0] FRAME_START    = 8'h57;
  localparam logic [7:0] FRAME_LEN_CODE = 8'h03;
  localparam logic [7:0] FRAME_TYPE     = 8'h56;
  localparam logic [7:0] FRAME_END      = 8'h58;

  // byte positions within a frame
  localparam logic [2:0] POS_START = 3'd0;
  localparam logic [2:0] POS_LEN   = 3'd1;
  localparam logic [2:0] POS_TYPE  = 3'd2;
  localparam logic [2:0] POS_LO    = 3'd3;
  localparam logic [2:0] POS_HI    = 3'd4;
  localparam logic [2:0] POS_END   = 3'd5;

  // pending frame queue
  localparam int unsigned FQ_DEPTH = 8;
  localparam int unsigned FQ_AW    = 3;
  localparam int unsigned FQ_CW    = 4;

  // floor(LOG_SCALE * ln(x + LOG_OFFSET)), evaluated at elaboration only
  function automatic logic [LOG_W-1:0] log_entry(int unsigned x);
    real arg;
    arg = real'(x + LOG_OFFSET);
    return LOG_W'($rtoi(LOG_SCALE * $ln(arg)));
  endfunction

endpackage

### hdl/log_average_deadband_framer.sv
// Log-scaled block averager with dead band. Each ADC sample is mapped to
// floor(1000*ln(sample+2000)) by a lookup ROM built at elaboration; GROUP_SIZE
// mapped values are summed and divided (truncating) by GROUP_SIZE. When the
// average moves by more than change_threshold from the last value sent, a
// six-byte frame 'W', 3, 'V', avg[7:0], avg[13:8], 'X' is queued (tlast on
// 'X') and the average becomes the new reference; reset clears it to zero.
// A sample is accepted every cycle while s_axis_tready is high; its frame passes
// the ROM lookup, sum, product, queue and serializer registers. Frame bytes
// leave one per cycle while m_axis_tready is high, paced by the output
// serializer; up to eight frames wait in a queue, and s_axis_tready drops
// while the queue plus the samples in flight could fill it.
module log_average_deadband_framer
  import ladf_pkg::*;
#(
  parameter int unsigned GROUP_SIZE  = 3,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,   // adc_sample
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [7:0]                           m_axis_tdata,   // frame_byte
  output logic                                 m_axis_tlast,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [THR_W-1:0]                     cfg_data_i      // change_threshold
);

  localparam int unsigned ROM_DEPTH = 2 ** SAMPLE_BITS;
  localparam int unsigned CLOG_G    = $clog2(GROUP_SIZE);
  localparam int unsigned CNT_W     = (GROUP_SIZE > 1) ? CLOG_G : 1;
  localparam int unsigned SUM_W     = LOG_W + CLOG_G;
  localparam int unsigned DIV_SH    = SUM_W + CLOG_G;
  localparam longint unsigned RECIP_L = ((64'd1 << DIV_SH) / GROUP_SIZE) + 64'd1;
  localparam logic [SUM_W:0]  RECIP   = RECIP_L[SUM_W:0];
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GROUP_SIZE - 1);

  typedef logic [LOG_W-1:0] rom_t [ROM_DEPTH];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      r[i] = log_entry(i);
    end
    return r;
  endfunction

  localparam rom_t LOG_ROM = build_rom();

  logic                 in_fire;
  logic                 out_fire;
  logic [THR_W-1:0]     thr_q;

  logic [LOG_W-1:0]     map_q;
  logic                 m_vld_q;
  logic [SUM_W-1:0]     acc_q, acc_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [SUM_W-1:0]     tot_q;
  logic                 tot_vld_q;
  logic [2*SUM_W:0]     prod_q;
  logic                 p_vld_q;
  logic [LOG_W-1:0]     avg;
  logic [LOG_W-1:0]     diff;
  logic [LOG_W-1:0]     last_q;
  logic                 push;

  logic [LOG_W-1:0]     fq_mem [FQ_DEPTH];
  logic [FQ_AW-1:0]     fq_wr_q, fq_rd_q;
  logic [FQ_CW-1:0]     fq_cnt_q, fq_cnt_d;
  logic [FQ_CW-1:0]     inflight;
  logic                 pop;

  logic                 act_q;
  logic [2:0]           pos_q;
  logic [LOG_W-1:0]     cur_q;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // ROM lookup
  always_ff @(posedge clk_i) begin
    map_q <= LOG_ROM[s_axis_tdata[SAMPLE_BITS-1:0]];
  end

  // group accumulation
  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (m_vld_q) begin
      if (cnt_q == CNT_LAST) begin
        acc_d = '0;
        cnt_d = '0;
      end else begin
        acc_d = acc_q + SUM_W'(map_q);
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q   <= 1'b0;
      acc_q     <= '0;
      cnt_q     <= '0;
      tot_vld_q <= 1'b0;
      p_vld_q   <= 1'b0;
    end else begin
      m_vld_q   <= in_fire;
      acc_q     <= acc_d;
      cnt_q     <= cnt_d;
      tot_vld_q <= m_vld_q && (cnt_q == CNT_LAST);
      p_vld_q   <= tot_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tot_q  <= acc_q + SUM_W'(map_q);
    prod_q <= (2*SUM_W+1)'(tot_q) * (2*SUM_W+1)'(RECIP);
  end

  // exact truncating divide by reciprocal
  assign avg  = prod_q[DIV_SH +: LOG_W];
  assign diff = (avg >= last_q) ? (avg - last_q) : (last_q - avg);
  assign push = p_vld_q && (diff > LOG_W'(thr_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (push) begin
      last_q <= avg;
    end
  end

  // frame queue
  assign pop = (fq_cnt_q != '0) && (!act_q || (out_fire && pos_q == POS_END));

  always_comb begin
    fq_cnt_d = fq_cnt_q;
    if (push && !pop) begin
      fq_cnt_d = fq_cnt_q + FQ_CW'(1);
    end else if (pop && !push) begin
      fq_cnt_d = fq_cnt_q - FQ_CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fq_mem[fq_wr_q] <= avg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fq_wr_q  <= '0;
      fq_rd_q  <= '0;
      fq_cnt_q <= '0;
    end else begin
      if (push) begin
        fq_wr_q <= fq_wr_q + FQ_AW'(1);
      end
      if (pop) begin
        fq_rd_q <= fq_rd_q + FQ_AW'(1);
      end
      fq_cnt_q <= fq_cnt_d;
    end
  end

  assign inflight = FQ_CW'(m_vld_q) + FQ_CW'(tot_vld_q) + FQ_CW'(p_vld_q);
  assign s_axis_tready = (fq_cnt_q + inflight) < FQ_CW'(FQ_DEPTH);

  // byte serializer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      pos_q <= POS_START;
    end else if (pop) begin
      act_q <= 1'b1;
      pos_q <= POS_START;
    end else if (out_fire) begin
      if (pos_q == POS_END) begin
        act_q <= 1'b0;
      end else begin
        pos_q <= pos_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= fq_mem[fq_rd_q];
    end
  end

  always_comb begin
    case (pos_q)
      POS_START: m_axis_tdata = FRAME_START;
      POS_LEN:   m_axis_tdata = FRAME_LEN_CODE;
      POS_TYPE:  m_axis_tdata = FRAME_TYPE;
      POS_LO:    m_axis_tdata = cur_q[7:0];
      POS_HI:    m_axis_tdata = 8'(cur_q[LOG_W-1:8]);
      POS_END:   m_axis_tdata = FRAME_END;
      default:   m_axis_tdata = 8'h00;
    endcase
  end

  assign m_axis_tvalid = act_q;
  assign m_axis_tlast  = (pos_q == POS_END);

  a_fq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fq_cnt_q <= FQ_CW'(FQ_DEPTH))
    else $error("frame queue count out of range");

  a_fq_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (fq_cnt_q < FQ_CW'(FQ_DEPTH)) || pop)
    else $error("frame queue overflow");

  a_ref_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !push |=> $stable(last_q))
    else $error("reference changed without a frame");

  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && m_axis_tlast && fq_cnt_q == '0) |=> !m_axis_tvalid)
    else $error("output valid without a queued frame");

endmodule

### tb/log_average_deadband_framer_tb.sv
module log_average_deadband_framer_tb;
  import ladf_pkg::*;

  localparam int unsigned GROUP_LEN      = 3;
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS    = 100;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [15:0]      s_axis_tdata;   // adc_sample
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [7:0]       m_axis_tdata;   // frame_byte
  logic             m_axis_tlast;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [THR_W-1:0] cfg_data_i;

  // mirror of the block state
  frame_byte_t      expected_bytes[$];
  int unsigned      level_sum;
  int unsigned      level_count;
  logic [13:0]      last_level;
  logic [THR_W-1:0] deadband;

  int unsigned      fail_count;
  int unsigned      idle_cycles;
  int unsigned      sink_hold_req;
  bit               src_gaps_on;
  bit               sink_gaps_on;
  bit               src_offering;

  log_average_deadband_framer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(10, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  // floor(1000 * ln(sample + 2000))
  function automatic int unsigned log_level(input logic [11:0] sample);
    real x;
    x = real'(int'(sample)) + 2000.0;
    return $rtoi(1000.0 * $ln(x));
  endfunction

  function automatic void predict_sample(input logic [15:0] raw);
    int unsigned avg;
    int unsigned diff;
    level_sum += log_level(raw[11:0]);
    level_count++;
    if (level_count < GROUP_LEN) return;
    avg = level_sum / GROUP_LEN;
    level_sum = 0;
    level_count = 0;
    diff = (avg >= last_level) ? avg - last_level : last_level - avg;
    if (diff <= deadband) return;
    last_level = avg[13:0];
    expected_bytes.push_back('{FRAME_START, 1'b0});
    expected_bytes.push_back('{FRAME_LEN_CODE, 1'b0});
    expected_bytes.push_back('{FRAME_TYPE, 1'b0});
    expected_bytes.push_back('{avg[7:0], 1'b0});
    expected_bytes.push_back('{avg[15:8], 1'b0});
    expected_bytes.push_back('{FRAME_END, 1'b1});
  endfunction

  task automatic send_sample(input logic [15:0] raw);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_sample(raw);
    gap = (src_gaps_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      src_offering = 1'b0;
      repeat (gap) @(posedge clk_i);
    end else begin
      src_offering = 1'b1;
    end
  endtask

  task automatic send_group(input logic [15:0] raw);
    repeat (GROUP_LEN) send_sample(raw);
  endtask

  // every expected byte out, then let non-framing groups settle
  task automatic drain_frames();
    if (src_offering) begin
      s_axis_tvalid <= 1'b0;
      src_offering = 1'b0;
    end
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    drain_frames();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    deadband = value;
    cfg_valid_i <= 1'b0;
  endtask

  // framing of both range ends; bits above the sample width are don't-care
  task automatic test_frame_fields();
    send_group(16'h0000);
    send_group(16'h0FFF);
    send_group(16'hFFFF);
    send_sample(16'hF000);
    send_sample(16'h0FFF);
    send_sample(16'h8000);
  endtask

  // change equal to the threshold sends nothing, one more sends a frame
  task automatic test_deadband_edge();
    int unsigned lvl;
    int unsigned lvl_delta;
    drain_frames();
    lvl       = log_level(12'd3000);
    lvl_delta = (lvl >= last_level) ? lvl - last_level : last_level - lvl;
    write_threshold(THR_W'(lvl_delta));
    send_group(16'd3000);
    write_threshold(THR_W'(lvl_delta - 1));
    send_group(16'd3000);
  endtask

  task automatic test_threshold_extremes();
    write_threshold('0);
    send_group(16'd2500);
    send_group(16'd2500);
    send_group(16'd2510);
    write_threshold('1);
    send_group(16'd0);
    send_group(16'd4095);
  endtask

  // sink held off while the source keeps pushing framing groups
  task automatic test_backpressure();
    write_threshold('0);
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    sink_hold_req = LONG_HOLD;
    for (int i = 0; i < 60; i++) begin
      send_sample(((i / GROUP_LEN) % 2 != 0) ? 16'd4095 : 16'd0);
    end
    drain_frames();
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
  endtask

  task automatic test_random_phases();
    logic [THR_W-1:0] settings[5];
    int               cur;
    logic [3:0]       upper;
    settings[0] = THR_W'($urandom_range(0, 1023));
    settings[1] = '0;
    settings[2] = '1;
    settings[3] = THR_RESET;
    settings[4] = THR_W'($urandom_range(0, 120));
    cur = $urandom_range(0, 4095);
    for (int p = 0; p < 5; p++) begin
      write_threshold(settings[p]);
      src_gaps_on  = (p != 1) && (p != 3);
      sink_gaps_on = (p != 2) && (p != 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 9) < 7) begin
          cur += int'($urandom_range(0, 160)) - 80;
          if (cur < 0) cur = 0;
          if (cur > 4095) cur = 4095;
        end else begin
          cur = $urandom_range(0, 4095);
        end
        upper = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'h0;
        send_sample({upper, 12'(cur)});
      end
    end
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
  endtask

  initial begin : sink_pacing
    int unsigned stall;
    stall = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold_req != 0) begin
        stall = sink_hold_req;
        sink_hold_req = 0;
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if (sink_gaps_on && $urandom_range(0, 4) == 0) stall = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin : check_frames
    frame_byte_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_bytes.size() == 0) begin
          $error("frame_byte: none expected, got %h (last %b)", m_axis_tdata, m_axis_tlast);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (m_axis_tdata !== want.data) begin
            $error("frame_byte: expected %h, got %h", want.data, m_axis_tdata);
            fail_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("frame_last: expected %b, got %b", want.last, m_axis_tlast);
            fail_count++;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("log_average_deadband_framer: mismatch");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    fail_count    = 0;
    idle_cycles   = 0;
    sink_hold_req = 0;
    src_gaps_on   = 1'b1;
    sink_gaps_on  = 1'b1;
    src_offering  = 1'b0;
    level_sum     = 0;
    level_count   = 0;
    last_level    = '0;
    deadband      = THR_RESET;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_frame_fields();
    test_deadband_edge();
    test_threshold_extremes();
    test_backpressure();
    test_random_phases();
    drain_frames();
    if (fail_count == 0) begin
      $display("log_average_deadband_framer: match");
    end else begin
      $display("log_average_deadband_framer: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
hdl/ladf_pkg.sv
hdl/log_average_deadband_framer.sv
tb/log_average_deadband_framer_tb.sv
